/* design/gse_pkg.sv */
// Shared types and constants for the GF(2) elimination core.
// No dependencies; every other design file imports this package.
package gse_pkg;

   // Width of one row word, and the most words emitted for one row
   localparam int WORD_BITS = 32;
   localparam int MAX_OUT   = 8;

   // Input item: one word of an eliminator or of a row to reduce
   typedef struct packed {
      logic        command;
      logic [7:0]  pivot_column;
      logic [2:0]  word_index;
      logic [31:0] data;
      logic        last_word;
   } req_type;

   // Result item: one word of the reduced row
   typedef struct packed {
      logic [2:0]  out_word_index;
      logic [31:0] out_data;
      logic        out_last;
      logic        status;
      logic [7:0]  lead_column;
   } rsp_type;

   // Item command codes
   localparam logic CMD_ELIM = 1'b0;
   localparam logic CMD_ROW  = 1'b1;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ELIM_MASK,
      ST_PASS,
      ST_CHECK,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   // Row unit control for one cycle
   typedef struct packed {
      logic issue;       // read one row word
      logic pass_start;  // restart leading column tracking
      logic xor_en;      // fold the eliminator word in and write back
   } row_ctl_type;

   // Eliminator store enables
   typedef struct packed {
      logic tab_we;
      logic tab_re;
      logic msk_we;
      logic msk_re;
   } elim_ctl_type;

   // Index of the highest set bit of a word (0 for a zero word)
   function automatic logic [4:0] msb32(logic [31:0] v);
      logic [4:0] idx;
      idx = '0;
      for (int k = 0; k < WORD_BITS; k++) begin
         if (v[k]) idx = 5'(k);
      end
      return idx;
   endfunction

endpackage

/* design/gf2_special_gaussian_elimination_core.sv */
// Top level of the GF(2) elimination core: controller and output register.
// Depends on gse_pkg, gse_elim_store and gse_row_unit.
//
//   channel  ports                       direction  transfer
//   request  start, busy, req_item       in         start high and busy low
//   result   rsp_strobe, rsp_item        out        one-cycle strobe per item, no stall
//
// An eliminator word holds busy through ST_ELIM_MASK; a row word without last_word
// leaves busy low. A row's last word starts one pass plus one per eliminator fold;
// each pass streams the row buffer (and on a fold the table memory) one word a
// cycle, then reads the slot mask at the new leading column.
// After reset a clearing pass over every table word runs
// with busy high. Results cannot be held off; busy covers the whole reduction.
module gf2_special_gaussian_elimination_core #(
   parameter int COLS  = 256,
   parameter int WORDS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gse_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output gse_pkg::rsp_type  rsp_item
);
   import gse_pkg::*;

   localparam int CW   = $clog2(COLS);
   localparam int LW   = $clog2(COLS + 1);
   localparam int WW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int WCW  = $clog2(WORDS + 1);
   localparam int NOUT = (WORDS < MAX_OUT) ? WORDS : MAX_OUT;

   state_type        state_ff, state_in;
   logic [WCW-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]    ccol_ff, ccol_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_item_ff, rsp_item_in;
   logic [LW-1:0]    prev_lead_ff, prev_lead_in;
   logic [LW-1:0]    out_lead_ff, out_lead_in;
   logic             first_ff, first_in;
   logic             xor_ff, xor_in;
   logic             status_ff, status_in;
   logic             promote_ff, promote_in;
   logic [CW-1:0]    epiv_ff, epiv_in;
   logic [WW-1:0]    ewi_ff, ewi_in;
   logic             enz_ff, enz_in;

   elim_ctl_type     ectl;
   logic [CW-1:0]    tab_wcol, tab_rcol, msk_wcol, msk_rcol;
   logic [WW-1:0]    tab_wword, tab_rword;
   logic [31:0]      tab_wdata, tab_rdata;
   logic [WORDS-1:0] msk_wdata, msk_rdata;

   row_ctl_type      rctl;
   logic [WW-1:0]    row_raddr, row_waddr;
   logic             row_we;
   logic [31:0]      row_wdata;
   logic             wv;
   logic [WW-1:0]    widx;
   logic [31:0]      wdata;
   logic [LW-1:0]    row_lead;
   logic [WORDS-1:0] row_nzw;

   logic             accept;
   logic [31:0]      din;
   logic             piv_ok, wi_ok;
   logic             lead_none, malformed, slot_valid;
   logic [WORDS-1:0] new_mask;

   // bits of word wi that fall on real columns
   function automatic logic [31:0] col_mask(logic [2:0] wi);
      logic [31:0] m;
      for (int k = 0; k < WORD_BITS; k++) begin
         m[k] = (32'({wi, 5'(k)}) < 32'(COLS));
      end
      return m;
   endfunction

   gse_elim_store #(.COLS(COLS), .WORDS(WORDS), .CW(CW), .WW(WW)) u_store (
      .clock     (clock),
      .ctl       (ectl),
      .tab_wcol  (tab_wcol),
      .tab_wword (tab_wword),
      .tab_wdata (tab_wdata),
      .tab_rcol  (tab_rcol),
      .tab_rword (tab_rword),
      .tab_rdata (tab_rdata),
      .msk_wcol  (msk_wcol),
      .msk_wdata (msk_wdata),
      .msk_rcol  (msk_rcol),
      .msk_rdata (msk_rdata)
   );

   gse_row_unit #(.COLS(COLS), .WORDS(WORDS), .LW(LW), .WW(WW)) u_row (
      .clock      (clock),
      .reset      (reset),
      .ctl        (rctl),
      .raddr      (row_raddr),
      .ext_we     (row_we),
      .ext_waddr  (row_waddr),
      .ext_wdata  (row_wdata),
      .tab_rdata  (tab_rdata),
      .word_valid (wv),
      .word_index (widx),
      .word_data  (wdata),
      .lead       (row_lead),
      .nzw        (row_nzw)
   );

   // input qualification
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign din    = req_item.data & col_mask(req_item.word_index);
   assign piv_ok = (32'(req_item.pivot_column) < 32'(COLS));
   assign wi_ok  = (32'(req_item.word_index) < 32'(WORDS));

   // decision inputs after a pass
   assign lead_none  = (row_lead == LW'(COLS));
   assign malformed  = !first_ff && (row_lead >= prev_lead_ff);
   assign slot_valid = |msk_rdata;

   // slot mask with one word's nonzero flag replaced
   always_comb begin
      for (int j = 0; j < WORDS; j++) begin
         new_mask[j] = (WW'(j) == ewi_ff) ? enz_ff : msk_rdata[j];
      end
   end

   // next state, memory control and result word
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ccol_in      = ccol_ff;
      prev_lead_in = prev_lead_ff;
      out_lead_in  = out_lead_ff;
      first_in     = first_ff;
      xor_in       = xor_ff;
      status_in    = status_ff;
      promote_in   = promote_ff;
      epiv_in      = epiv_ff;
      ewi_in       = ewi_ff;
      enz_in       = enz_ff;

      ectl      = '0;
      tab_wcol  = CW'(out_lead_ff);
      tab_wword = widx;
      tab_wdata = wdata;
      tab_rcol  = CW'(prev_lead_ff);
      tab_rword = cnt_ff[WW-1:0];
      msk_wcol  = epiv_ff;
      msk_wdata = new_mask;
      msk_rcol  = CW'(row_lead);

      rctl      = '0;
      row_raddr = cnt_ff[WW-1:0];
      row_we    = 1'b0;
      row_waddr = cnt_ff[WW-1:0];
      row_wdata = 32'h0;

      // emitted words, and copy into the table on promotion
      rsp_strobe_in              = 1'b0;
      rsp_item_in.out_word_index = 3'(widx);
      rsp_item_in.out_data       = wdata;
      rsp_item_in.out_last       = (32'(widx) == 32'(NOUT - 1));
      rsp_item_in.status         = status_ff;
      rsp_item_in.lead_column    = status_ff ? 8'(out_lead_ff) : 8'h0;
      if (state_ff == ST_EMIT && wv) begin
         rsp_strobe_in = (32'(widx) < 32'(NOUT));
         ectl.tab_we   = promote_ff;
      end

      case (state_ff)
         // zero table, slot masks and row buffer, one table word a cycle
         ST_CLEAR: begin
            ectl.tab_we = 1'b1;
            tab_wcol    = ccol_ff;
            tab_wword   = cnt_ff[WW-1:0];
            tab_wdata   = 32'h0;
            ectl.msk_we = (cnt_ff == '0);
            msk_wcol    = ccol_ff;
            msk_wdata   = '0;
            row_we      = (ccol_ff == '0);
            if (cnt_ff == WCW'(WORDS - 1)) begin
               cnt_in = '0;
               if (ccol_ff == CW'(COLS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  ccol_in = ccol_ff + 1'b1;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               if (req_item.command == CMD_ELIM) begin
                  if (piv_ok && wi_ok) begin
                     ectl.tab_we = 1'b1;
                     tab_wcol    = CW'(req_item.pivot_column);
                     tab_wword   = WW'(req_item.word_index);
                     tab_wdata   = din;
                     ectl.msk_re = 1'b1;
                     msk_rcol    = CW'(req_item.pivot_column);
                     epiv_in     = CW'(req_item.pivot_column);
                     ewi_in      = WW'(req_item.word_index);
                     enz_in      = (din != 32'h0);
                     state_in    = ST_ELIM_MASK;
                  end
               end else begin
                  row_we    = wi_ok;
                  row_waddr = WW'(req_item.word_index);
                  row_wdata = din;
                  if (req_item.last_word) begin
                     cnt_in   = '0;
                     xor_in   = 1'b0;
                     first_in = 1'b1;
                     state_in = ST_PASS;
                  end
               end
            end
         end

         // rewrite the slot mask with the new word's flag
         ST_ELIM_MASK: begin
            ectl.msk_we = 1'b1;
            state_in    = ST_IDLE;
         end

         // stream the row, folding the eliminator in when xor is set
         ST_PASS: begin
            if (cnt_ff < WCW'(WORDS)) begin
               rctl.issue      = 1'b1;
               rctl.pass_start = (cnt_ff == '0);
               rctl.xor_en     = xor_ff;
               ectl.tab_re     = xor_ff;
               cnt_in          = cnt_ff + 1'b1;
            end else begin
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            ectl.msk_re = 1'b1;
            state_in    = ST_DECIDE;
         end

         // fold again, or finish and promote a row that found no eliminator
         ST_DECIDE: begin
            cnt_in = '0;
            if (lead_none || malformed || !slot_valid) begin
               status_in   = !lead_none;
               promote_in  = !lead_none && !slot_valid;
               out_lead_in = row_lead;
               ectl.msk_we = !lead_none && !slot_valid;
               msk_wcol    = CW'(row_lead);
               msk_wdata   = row_nzw;
               state_in    = ST_EMIT;
            end else begin
               prev_lead_in = row_lead;
               first_in     = 1'b0;
               xor_in       = 1'b1;
               state_in     = ST_PASS;
            end
         end

         // read each word out and clear it behind the read
         ST_EMIT: begin
            if (cnt_ff < WCW'(WORDS)) begin
               rctl.issue = 1'b1;
               row_we     = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         ccol_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         ccol_ff       <= ccol_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // working registers, always written before they are read
   always_ff @(posedge clock) begin
      rsp_item_ff  <= rsp_item_in;
      prev_lead_ff <= prev_lead_in;
      out_lead_ff  <= out_lead_in;
      first_ff     <= first_in;
      xor_ff       <= xor_in;
      status_ff    <= status_in;
      promote_ff   <= promote_in;
      epiv_ff      <= epiv_in;
      ewi_ff       <= ewi_in;
      enz_ff       <= enz_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

/* design/gse_elim_store.sv */
// Eliminator table memory plus a per-slot mask of nonzero words.
// Depends on gse_pkg; both memories have registered reads.
module gse_elim_store #(
   parameter int COLS  = 256,
   parameter int WORDS = 8,
   parameter int CW    = $clog2(COLS),
   parameter int WW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic                    clock,
   input  gse_pkg::elim_ctl_type   ctl,
   input  logic [CW-1:0]           tab_wcol,
   input  logic [WW-1:0]           tab_wword,
   input  logic [31:0]             tab_wdata,
   input  logic [CW-1:0]           tab_rcol,
   input  logic [WW-1:0]           tab_rword,
   output logic [31:0]             tab_rdata,
   input  logic [CW-1:0]           msk_wcol,
   input  logic [WORDS-1:0]        msk_wdata,
   input  logic [CW-1:0]           msk_rcol,
   output logic [WORDS-1:0]        msk_rdata
);
   import gse_pkg::*;

   localparam int TAW = $clog2(COLS * WORDS);

   logic [31:0]      tab_mem [COLS*WORDS];
   logic [WORDS-1:0] msk_mem [COLS];
   logic [31:0]      tab_rdata_ff;
   logic [WORDS-1:0] msk_rdata_ff;
   logic [TAW-1:0]   tab_waddr;
   logic [TAW-1:0]   tab_raddr;

   // slot-major layout: column times row length plus word
   assign tab_waddr = TAW'(tab_wcol) * TAW'(WORDS) + TAW'(tab_wword);
   assign tab_raddr = TAW'(tab_rcol) * TAW'(WORDS) + TAW'(tab_rword);

   always_ff @(posedge clock) begin
      if (ctl.tab_we) tab_mem[tab_waddr] <= tab_wdata;
      if (ctl.tab_re) tab_rdata_ff <= tab_mem[tab_raddr];
   end

   // slot is valid while any bit of its mask is set
   always_ff @(posedge clock) begin
      if (ctl.msk_we) msk_mem[msk_wcol] <= msk_wdata;
      if (ctl.msk_re) msk_rdata_ff <= msk_mem[msk_rcol];
   end

   assign tab_rdata = tab_rdata_ff;
   assign msk_rdata = msk_rdata_ff;

endmodule

/* design/gse_row_unit.sv */
// Row buffer memory with the word pipeline: XOR fold, write back and
// leading column tracking. Depends on gse_pkg.
module gse_row_unit #(
   parameter int COLS  = 256,
   parameter int WORDS = 8,
   parameter int LW    = $clog2(COLS + 1),
   parameter int WW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gse_pkg::row_ctl_type  ctl,
   input  logic [WW-1:0]         raddr,
   input  logic                  ext_we,
   input  logic [WW-1:0]         ext_waddr,
   input  logic [31:0]           ext_wdata,
   input  logic [31:0]           tab_rdata,
   output logic                  word_valid,
   output logic [WW-1:0]         word_index,
   output logic [31:0]           word_data,
   output logic [LW-1:0]         lead,
   output logic [WORDS-1:0]      nzw
);
   import gse_pkg::*;

   logic [31:0]      row_mem [WORDS];
   logic [31:0]      row_q_ff;
   logic             pv_ff;
   logic [WW-1:0]    pa_ff;
   logic             px_ff;
   logic [LW-1:0]    lead_ff;
   logic [WORDS-1:0] nzw_ff;
   logic [31:0]      word;
   logic             we;
   logic [WW-1:0]    waddr;
   logic [31:0]      wdata;
   logic [WW+4:0]    lead_raw;

   // returning word, with the eliminator folded in on a reduction pass
   assign word     = row_q_ff ^ (px_ff ? tab_rdata : 32'h0);
   assign lead_raw = {pa_ff, msb32(word)};

   // write-back has the port; outside writes only come in other phases
   always_comb begin
      if (pv_ff && px_ff) begin
         we    = 1'b1;
         waddr = pa_ff;
         wdata = word;
      end else begin
         we    = ext_we;
         waddr = ext_waddr;
         wdata = ext_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (we) row_mem[waddr] <= wdata;
      if (ctl.issue) row_q_ff <= row_mem[raddr];
   end

   // pipeline tags for the word in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= ctl.issue;
      end
      pa_ff <= raddr;
      px_ff <= ctl.xor_en;
   end

   // words come back in ascending order, so the last nonzero one leads
   always_ff @(posedge clock) begin
      if (reset || ctl.pass_start) begin
         lead_ff <= LW'(COLS);
         nzw_ff  <= '0;
      end else if (pv_ff) begin
         if (word != 32'h0) lead_ff <= LW'(lead_raw);
         nzw_ff[pa_ff] <= (word != 32'h0);
      end
   end

   assign word_valid = pv_ff;
   assign word_index = pa_ff;
   assign word_data  = word;
   assign lead       = lead_ff;
   assign nzw        = nzw_ff;

endmodule

/* dv/gf2_special_gaussian_elimination_core_tb.sv */
// Self-checking testbench for the GF(2) elimination core: directed and random items,
// with a scoreboard class that predicts every reduced row word. Needs gse_pkg and the core.
`timescale 1ns / 100ps

module gf2_special_gaussian_elimination_core_tb;
   import gse_pkg::*;

   localparam int NUM_COLS   = 256;
   localparam int NUM_WORDS  = 8;
   localparam int CYCLE_CAP  = 4000000;
   localparam int DRAIN      = 64;
   localparam int RAND_ITEMS = 76;

   // Tracks the eliminator table and the row buffer, and queues expected row words
   class gf2_reduction_scoreboard;
      bit [31:0] elim_words [NUM_COLS][NUM_WORDS];
      bit        elim_live  [NUM_COLS];
      bit [31:0] row_words  [NUM_WORDS];
      rsp_type   expected_words[$];
      int        mismatches;

      // Highest set column of the row, NUM_COLS when the row is zero
      function int row_lead();
         for (int w = NUM_WORDS - 1; w >= 0; w--) begin
            for (int b = 31; b >= 0; b--) begin
               if (row_words[w][b]) return 32 * w + b;
            end
         end
         return NUM_COLS;
      endfunction

      // With 256 columns and 8 words every field value is in range, so no masking
      function void note_item(req_type r);
         int      lead;
         int      next_lead;
         bit      any_set;
         bit      nonzero;
         rsp_type e;
         if (r.command == CMD_ELIM) begin
            elim_words[r.pivot_column][r.word_index] = r.data;
            any_set = 1'b0;
            for (int w = 0; w < NUM_WORDS; w++) any_set |= (elim_words[r.pivot_column][w] != 0);
            elim_live[r.pivot_column] = any_set;
            return;
         end
         row_words[r.word_index] = r.data;
         if (!r.last_word) return;
         // fold eliminators in until the row is zero, unmatched, or fails to drop
         lead = row_lead();
         while (lead < NUM_COLS && elim_live[lead]) begin
            for (int w = 0; w < NUM_WORDS; w++) row_words[w] ^= elim_words[lead][w];
            next_lead = row_lead();
            if (next_lead < NUM_COLS && next_lead >= lead) begin
               lead = next_lead;
               break;
            end
            lead = next_lead;
         end
         nonzero = (lead < NUM_COLS);
         // promote into a free slot only
         if (nonzero && !elim_live[lead]) begin
            for (int w = 0; w < NUM_WORDS; w++) elim_words[lead][w] = row_words[w];
            elim_live[lead] = 1'b1;
         end
         for (int w = 0; w < NUM_WORDS; w++) begin
            e.out_word_index = 3'(w);
            e.out_data       = row_words[w];
            e.out_last       = (w == NUM_WORDS - 1);
            e.status         = nonzero;
            e.lead_column    = nonzero ? 8'(lead) : 8'd0;
            expected_words.push_back(e);
         end
         for (int w = 0; w < NUM_WORDS; w++) row_words[w] = '0;
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected row word idx=%0d data=%08h last=%0b st=%0b lead=%0d",
                        $time, got.out_word_index, got.out_data, got.out_last, got.status,
                        got.lead_column);
            return;
         end
         want = expected_words.pop_front();
         if (got.out_word_index !== want.out_word_index || got.out_data !== want.out_data ||
             got.out_last !== want.out_last || got.status !== want.status ||
             got.lead_column !== want.lead_column) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: row word mismatch exp idx=%0d data=%08h last=%0b st=%0b lead=%0d",
                        $time, want.out_word_index, want.out_data, want.out_last, want.status,
                        want.lead_column,
                        " got idx=%0d data=%08h last=%0b st=%0b lead=%0d",
                        got.out_word_index, got.out_data, got.out_last, got.status,
                        got.lead_column);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   gf2_reduction_scoreboard sb = new();
   int          idle_pct;
   int          items_sent;
   int unsigned cycle_count = 0;

   gf2_special_gaussian_elimination_core #(
      .COLS  (NUM_COLS),
      .WORDS (NUM_WORDS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result monitor; an unknown strobe counts as a result
   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) sb.check_word(rsp_item);
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("FAIL gf2_special_gaussian_elimination_core");
         $finish;
      end
   end

   function automatic req_type pack_item(logic cmd, logic [7:0] piv, logic [2:0] wi,
                                         logic [31:0] data, logic last);
      req_type r;
      r.command      = cmd;
      r.pivot_column = piv;
      r.word_index   = wi;
      r.data         = data;
      r.last_word    = last;
      return r;
   endfunction

   // Mix of zero, all ones, single bits and dense words
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Called and returns at a falling edge; start stays high until the caller idles
   task automatic send_item(input req_type item);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_item <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_item(item);
      items_sent++;
      @(negedge clock);
   endtask

   // Well-formed eliminator: leading column equals its slot
   task automatic load_eliminator(input int slot);
      int          top;
      logic [31:0] lead_bit;
      logic [31:0] data;
      top      = slot / 32;
      lead_bit = 32'h1 << (slot % 32);
      for (int w = 0; w <= top; w++) begin
         data = rand_word();
         if (w == top) data = (data & (lead_bit - 1)) | lead_bit;
         send_item(pack_item(CMD_ELIM, 8'(slot), 3'(w), data, 1'b0));
      end
      // sometimes scrub stale words above the lead
      if ($urandom_range(0, 99) < 30) begin
         for (int w = top + 1; w < NUM_WORDS; w++)
            send_item(pack_item(CMD_ELIM, 8'(slot), 3'(w), 32'h0, 1'b0));
      end
   endtask

   // Row to reduce; mostly confined to the low words so the table fills there
   task automatic reduce_random_row();
      int top;
      top = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 1) : $urandom_range(0, 7);
      for (int w = 0; w <= top; w++) begin
         if (w == top || $urandom_range(0, 3) != 0)
            send_item(pack_item(CMD_ROW, 8'($urandom), 3'(w), rand_word(), w == top));
      end
   endtask

   // Stray words: bare eliminator writes, ignored last flags, rows left open
   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: send_item(pack_item(CMD_ELIM, 8'($urandom), 3'($urandom), rand_word(), 1'b0));
         1: send_item(pack_item(CMD_ELIM, 8'($urandom), 3'($urandom), rand_word(), 1'b1));
         default: send_item(pack_item(CMD_ROW, 8'($urandom), 3'($urandom), rand_word(), 1'b0));
      endcase
   endtask

   initial begin
      int phase_pct [4];
      int roll;
      int goal;
      // no idling, sender idle, receiver stall phase (it cannot stall, so none), both
      phase_pct = '{0, 82, 0, 22};
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      idle_pct    = 0;
      items_sent  = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero row, then the top column promoted and cancelled
      send_item(pack_item(CMD_ROW, 8'h00, 3'd0, 32'h0, 1'b1));
      send_item(pack_item(CMD_ROW, 8'h00, 3'd7, 32'hFFFF_FFFF, 1'b1));
      send_item(pack_item(CMD_ROW, 8'h00, 3'd7, 32'hFFFF_FFFF, 1'b1));
      // last flag on an eliminator word is ignored
      send_item(pack_item(CMD_ELIM, 8'd5, 3'd0, 32'h0000_0020, 1'b1));
      // fold down to column 0 and promote it, then cancel against it
      send_item(pack_item(CMD_ROW, 8'hFF, 3'd0, 32'h0000_0021, 1'b1));
      send_item(pack_item(CMD_ROW, 8'h00, 3'd0, 32'h0000_0001, 1'b1));
      // zeroing the only word frees the slot again
      send_item(pack_item(CMD_ELIM, 8'd5, 3'd0, 32'h0, 1'b0));
      send_item(pack_item(CMD_ROW, 8'h00, 3'd0, 32'h0000_0020, 1'b1));
      // malformed eliminator lifts the lead: stop, promote into the free slot, then not
      send_item(pack_item(CMD_ELIM, 8'd40, 3'd2, 32'h0000_0001, 1'b0));
      send_item(pack_item(CMD_ROW, 8'h00, 3'd1, 32'h0000_0100, 1'b1));
      send_item(pack_item(CMD_ROW, 8'h00, 3'd1, 32'h0000_0100, 1'b1));
      // row built from several words before its last one
      send_item(pack_item(CMD_ROW, 8'h00, 3'd2, 32'h1234_5678, 1'b0));
      send_item(pack_item(CMD_ROW, 8'h00, 3'd5, 32'hDEAD_BEEF, 1'b0));
      send_item(pack_item(CMD_ROW, 8'h00, 3'd6, 32'h8000_0000, 1'b1));
      // full-width eliminator at column 128
      for (int w = 0; w < 4; w++)
         send_item(pack_item(CMD_ELIM, 8'd128, 3'(w), 32'hFFFF_FFFF, 1'b0));
      send_item(pack_item(CMD_ELIM, 8'd128, 3'd4, 32'h0000_0001, 1'b0));
      send_item(pack_item(CMD_ROW, 8'h00, 3'd4, 32'h0000_0001, 1'b1));
      // malformed word at the top of slot 0xAA, then a fold from the top column
      send_item(pack_item(CMD_ELIM, 8'hAA, 3'd7, 32'h5555_5555, 1'b0));
      send_item(pack_item(CMD_ROW, 8'h00, 3'd7, 32'h8000_0000, 1'b1));
      send_item(pack_item(CMD_ROW, 8'h00, 3'd5, 32'h0040_0000, 1'b1));

      // random part in four idling phases
      goal = items_sent + RAND_ITEMS;
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = phase_pct[ph];
         while (items_sent < goal - (3 - ph) * (RAND_ITEMS / 4)) begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
               reduce_random_row();
            else if (roll < 85)
               load_eliminator(($urandom_range(0, 99) < 60) ? $urandom_range(0, 63)
                                                            : $urandom_range(0, 255));
            else
               send_noise();
         end
      end

      // drain
      start <= 1'b0;
      while (sb.expected_words.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_words.size() == 0)
         $display("PASS gf2_special_gaussian_elimination_core");
      else
         $display("FAIL gf2_special_gaussian_elimination_core");
      $finish;
   end

endmodule

/* files.f */
design/gse_pkg.sv
design/gse_elim_store.sv
design/gse_row_unit.sv
design/gf2_special_gaussian_elimination_core.sv
dv/gf2_special_gaussian_elimination_core_tb.sv
